// ----- design/stafr_pkg.sv -----
// Shared constants, codes and flash image helpers for the SPI touch/flash responder.
package stafr_pkg;

	// Control register fields
	localparam int unsigned CTL_ENABLE_BIT = 15;
	localparam int unsigned CTL_HOLD_BIT   = 11;
	localparam logic [1:0]  DEV_FLASH      = 2'd1;
	localparam logic [1:0]  DEV_TOUCH      = 2'd2;

	// Bus offsets
	localparam logic [1:0] OFF_CTL_LO = 2'd0;
	localparam logic [1:0] OFF_CTL_HI = 2'd1;
	localparam logic [1:0] OFF_DATA   = 2'd2;

	// Access types
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// Flash command state
	localparam logic [1:0] FCMD_NONE = 2'd0;
	localparam logic [1:0] FCMD_READ = 2'd1;
	localparam logic [1:0] FCMD_RDSR = 2'd2;

	// Flash opcodes
	localparam logic [7:0] OP_READ = 8'h03;
	localparam logic [7:0] OP_RDSR = 8'h05;

	// Touch reply index meaning no reply pending
	localparam logic [1:0] REPLY_NONE = 2'd2;

	// Touch ADC channels
	localparam logic [2:0] CH_Y   = 3'd1;
	localparam logic [2:0] CH_X   = 3'd5;
	localparam logic [2:0] CH_AUX = 3'd6;

	// User settings window in the flash image
	localparam logic [31:0] SET_LO   = 32'h0003_FE00;
	localparam logic [31:0] SET_HI   = 32'h0004_0000;
	localparam logic [7:0]  SET_BODY = 8'h70;

	// Nonzero bytes of the user settings body
	function automatic logic [7:0] settings_body(input logic [7:0] off);
		logic [7:0] b;
		case (off)
			8'h00: b = 8'h05;
			8'h02: b = 8'h07;
			8'h03: b = 8'h06;
			8'h04: b = 8'h17;
			8'h59: b = 8'h02;
			8'h5B: b = 8'h02;
			8'h5C: b = 8'h21;
			8'h5D: b = 8'h21;
			8'h5F: b = 8'h0E;
			8'h61: b = 8'h08;
			8'h62: b = 8'hE1;
			8'h63: b = 8'h81;
			8'h64: b = 8'h31;
			8'h65: b = 8'hFC;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// CRC-16 (reflected 0xA001, init 0xFFFF) over the settings body, elaboration only
	function automatic logic [15:0] settings_crc();
		logic [15:0] crc;
		crc = 16'hFFFF;
		for (int i = 0; i < 32'h70; i++) begin
			crc = crc ^ {8'h00, settings_body(8'(i))};
			for (int b = 0; b < 8; b++) begin
				if (crc[0]) begin
					crc = (crc >> 1) ^ 16'hA001;
				end else begin
					crc = crc >> 1;
				end
			end
		end
		return crc;
	endfunction

	localparam logic [15:0] SETTINGS_CRC = settings_crc();

endpackage

// ----- design/spi_touch_adc_and_flash_responder.sv -----
// Top level: SPI control/data register responder for a touch ADC and a firmware flash.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------------------
//  request | req_valid | req_stall | req_type reg_offset write_data pen_x pen_y pen_down
//  reply   | rsp_valid | rsp_stall | read_data
//
// Every transaction gives one reply byte. A transaction is captured in the input
// register, then passes through the register update logic into the reply register.
// One transaction per cycle is sustained while the reply side does not stall; a
// stalled reply holds the input register, which then stalls the request side.
// arst_n clears all control state and registers asynchronously.
module spi_touch_adc_and_flash_responder #(
	parameter int unsigned FLASH_ADDR_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        req_type,
	input  logic [1:0]  reg_offset,
	input  logic [7:0]  write_data,
	input  logic [11:0] pen_x,
	input  logic [11:0] pen_y,
	input  logic        pen_down,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [7:0]  read_data
);

	localparam int unsigned AW = FLASH_ADDR_BITS;

	// Input register
	logic        valid_s1;
	logic        type_s1;
	logic [1:0]  off_s1;
	logic [7:0]  wdata_s1;
	logic [11:0] pen_x_s1;
	logic [11:0] pen_y_s1;
	logic        pen_down_s1;

	// Reply register
	logic       rsp_valid_q;
	logic [7:0] rdata_q;

	// Block state
	logic [15:0]   ctl_q,    ctl_n;
	logic [7:0]    data_q,   data_n;
	logic [2:0]    chan_q,   chan_n;
	logic          eight_q,  eight_n;
	logic [11:0]   conv_q,   conv_n;
	logic [1:0]    reply_q,  reply_n;
	logic          fsel_q,   fsel_n;
	logic [1:0]    fcmd_q,   fcmd_n;
	logic [AW-1:0] faddr_q,  faddr_n;
	logic [1:0]    fcnt_q,   fcnt_n;

	logic          go;
	logic [7:0]    rd;
	logic          touch_on;
	logic          flash_on;
	logic          touch_on_new;
	logic          flash_on_new;
	logic [15:0]   ctl_new;
	logic [1:0]    fcmd_eff;
	logic [AW-1:0] faddr_eff;
	logic [1:0]    fcnt_eff;
	logic [7:0]    img_byte;
	logic [11:0]   conv_sel;
	logic [11:0]   shaped;
	logic [1:0]    reply_cur;

	// Handshake
	assign go        = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !go;
	assign rsp_valid = rsp_valid_q;
	assign read_data = rdata_q;

	assign touch_on = ctl_q[stafr_pkg::CTL_ENABLE_BIT] && (ctl_q[9:8] == stafr_pkg::DEV_TOUCH);
	assign flash_on = ctl_q[stafr_pkg::CTL_ENABLE_BIT] && (ctl_q[9:8] == stafr_pkg::DEV_FLASH);

	// Control byte write merged into the control register
	always_comb begin
		ctl_new = ctl_q;
		if (off_s1 == stafr_pkg::OFF_CTL_LO) begin
			ctl_new[7:0] = wdata_s1;
		end else if (off_s1 == stafr_pkg::OFF_CTL_HI) begin
			ctl_new[15:8] = wdata_s1;
		end
	end
	assign touch_on_new = ctl_new[stafr_pkg::CTL_ENABLE_BIT] &&
		(ctl_new[9:8] == stafr_pkg::DEV_TOUCH);
	assign flash_on_new = ctl_new[stafr_pkg::CTL_ENABLE_BIT] &&
		(ctl_new[9:8] == stafr_pkg::DEV_FLASH);

	// A deselected flash starts a fresh command
	assign fcmd_eff  = fsel_q ? fcmd_q  : stafr_pkg::FCMD_NONE;
	assign faddr_eff = fsel_q ? faddr_q : '0;
	assign fcnt_eff  = fsel_q ? fcnt_q  : 2'd0;

	stafr_flash_img #(
		.ADDR_BITS(AW)
	) u_img (
		.addr  (faddr_eff),
		.rdata (img_byte)
	);

	// Touch conversion for the channel in the command byte
	always_comb begin
		case (wdata_s1[6:4])
			stafr_pkg::CH_X:   conv_sel = pen_down_s1 ? pen_x_s1 : 12'h000;
			stafr_pkg::CH_Y:   conv_sel = pen_down_s1 ? pen_y_s1 : 12'hFFF;
			stafr_pkg::CH_AUX: conv_sel = 12'h800;
			default:           conv_sel = 12'hFFF;
		endcase
	end

	// Register update and reply byte for one transaction
	always_comb begin
		ctl_n   = ctl_q;
		data_n  = data_q;
		chan_n  = chan_q;
		eight_n = eight_q;
		conv_n  = conv_q;
		reply_n = reply_q;
		fsel_n  = fsel_q;
		fcmd_n  = fcmd_q;
		faddr_n = faddr_q;
		fcnt_n  = fcnt_q;
		rd      = 8'h00;
		shaped  = 12'h000;
		reply_cur = reply_q;

		if (type_s1 == stafr_pkg::REQ_READ) begin
			case (off_s1)
				stafr_pkg::OFF_CTL_LO: rd = {1'b0, ctl_q[6:0]};
				stafr_pkg::OFF_CTL_HI: rd = ctl_q[15:8];
				stafr_pkg::OFF_DATA:   rd = data_q;
				default:               rd = 8'h00;
			endcase
		end else if (off_s1 == stafr_pkg::OFF_DATA) begin
			if (touch_on) begin
				// touch ADC: start bit latches a new conversion
				if (wdata_s1[7]) begin
					chan_n  = wdata_s1[6:4];
					eight_n = wdata_s1[3];
					conv_n  = conv_sel;
					reply_cur = 2'd0;
				end
				shaped = eight_n ? (conv_n & 12'hFF0) : conv_n;
				case (reply_cur)
					2'd0:    data_n = {1'b0, shaped[11:5]};
					2'd1:    data_n = {shaped[4:0], 3'b000};
					default: data_n = 8'h00;
				endcase
				reply_n = (reply_cur < stafr_pkg::REPLY_NONE) ? reply_cur + 2'd1 : reply_cur;
				if (!ctl_q[stafr_pkg::CTL_HOLD_BIT]) begin
					reply_n = stafr_pkg::REPLY_NONE;
				end
			end else if (flash_on) begin
				// flash: command, address bytes, then data stream
				fcmd_n  = fcmd_eff;
				faddr_n = faddr_eff;
				fcnt_n  = fcnt_eff;
				data_n  = 8'hFF;
				if (fcmd_eff == stafr_pkg::FCMD_RDSR) begin
					data_n = 8'h00;
				end else if (fcmd_eff == stafr_pkg::FCMD_READ && fcnt_eff == 2'd3) begin
					data_n  = img_byte;
					faddr_n = faddr_eff + 1'b1;
				end else if (fcmd_eff == stafr_pkg::FCMD_READ) begin
					faddr_n = {faddr_eff[AW-9:0], wdata_s1};
					fcnt_n  = fcnt_eff + 2'd1;
				end else if (wdata_s1 == stafr_pkg::OP_READ) begin
					fcmd_n  = stafr_pkg::FCMD_READ;
					faddr_n = '0;
					fcnt_n  = 2'd0;
				end else if (wdata_s1 == stafr_pkg::OP_RDSR) begin
					fcmd_n = stafr_pkg::FCMD_RDSR;
				end else begin
					fcmd_n = stafr_pkg::FCMD_NONE;
				end
				fsel_n = ctl_q[stafr_pkg::CTL_HOLD_BIT];
			end
		end else begin
			// control or unmapped write, then the deselect rule
			ctl_n = ctl_new;
			if (!touch_on_new) begin
				reply_n = stafr_pkg::REPLY_NONE;
				if (!flash_on_new) begin
					fsel_n = 1'b0;
				end
			end
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			type_s1     <= 1'b0;
			off_s1      <= 2'd0;
			wdata_s1    <= 8'h00;
			pen_x_s1    <= 12'h000;
			pen_y_s1    <= 12'h000;
			pen_down_s1 <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				valid_s1    <= 1'b1;
				type_s1     <= req_type;
				off_s1      <= reg_offset;
				wdata_s1    <= write_data;
				pen_x_s1    <= pen_x;
				pen_y_s1    <= pen_y;
				pen_down_s1 <= pen_down;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Block state and reply register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rdata_q     <= 8'h00;
			ctl_q       <= 16'h0000;
			data_q      <= 8'h00;
			chan_q      <= 3'd0;
			eight_q     <= 1'b0;
			conv_q      <= 12'h000;
			reply_q     <= stafr_pkg::REPLY_NONE;
			fsel_q      <= 1'b0;
			fcmd_q      <= stafr_pkg::FCMD_NONE;
			faddr_q     <= '0;
			fcnt_q      <= 2'd0;
		end else begin
			if (go) begin
				rsp_valid_q <= 1'b1;
				rdata_q     <= rd;
				ctl_q       <= ctl_n;
				data_q      <= data_n;
				chan_q      <= chan_n;
				eight_q     <= eight_n;
				conv_q      <= conv_n;
				reply_q     <= reply_n;
				fsel_q      <= fsel_n;
				fcmd_q      <= fcmd_n;
				faddr_q     <= faddr_n;
				fcnt_q      <= fcnt_n;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/stafr_flash_img.sv -----
// Fixed firmware flash image: header bytes, settings mirrors with CRC, 0xFF elsewhere.
module stafr_flash_img #(
	parameter int unsigned ADDR_BITS = 24
) (
	input  logic [ADDR_BITS-1:0] addr,
	output logic [7:0]           rdata
);

	logic [31:0] a32;
	logic [7:0]  off;

	assign a32 = 32'(addr);
	assign off = a32[7:0];

	always_comb begin
		rdata = 8'hFF;
		if (a32 >= stafr_pkg::SET_LO && a32 < stafr_pkg::SET_HI) begin
			// settings mirror: body, mirror count, pad, CRC
			if (off < stafr_pkg::SET_BODY) begin
				rdata = stafr_pkg::settings_body(off);
			end else begin
				case (off)
					8'h70: rdata = {7'd0, a32[8]};
					8'h71: rdata = 8'h00;
					8'h72: rdata = stafr_pkg::SETTINGS_CRC[7:0];
					8'h73: rdata = stafr_pkg::SETTINGS_CRC[15:8];
					default: rdata = 8'hFF;
				endcase
			end
		end else if (a32 < 32'h40) begin
			// header region
			case (a32[5:0])
				6'h20: rdata = 8'hC0;
				6'h21: rdata = 8'h7F;
				6'h2C: rdata = 8'h38;
				6'h2D: rdata = 8'h01;
				6'h36: rdata = 8'h00;
				6'h37: rdata = 8'h09;
				6'h38: rdata = 8'hBF;
				6'h39: rdata = 8'h12;
				6'h3A: rdata = 8'h34;
				6'h3B: rdata = 8'h56;
				6'h3C: rdata = 8'hFE;
				6'h3D: rdata = 8'h3F;
				default: rdata = 8'hFF;
			endcase
		end
	end

endmodule
